// ----- rtl/bsort_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bsort_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned WIDTH    = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned RND_W    = $clog2(DEPTH);
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_COMPARE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic parity;
    logic desc;
    logic sgn;
  } cell_ctl_t;

  // a goes before b; an empty slot goes after every stored value
  function automatic logic goes_before(
    input logic [WIDTH-1:0] a,
    input logic             a_vld,
    input logic [WIDTH-1:0] b,
    input logic             b_vld,
    input logic             desc,
    input logic             sgn
  );
    logic [WIDTH-1:0] ka;
    logic [WIDTH-1:0] kb;
    logic             lt;
    logic             gt;
    ka = a;
    kb = b;
    ka[WIDTH-1] = a[WIDTH-1] ^ sgn;
    kb[WIDTH-1] = b[WIDTH-1] ^ sgn;
    lt = ka < kb;
    gt = ka > kb;
    return a_vld & (~b_vld | (desc ? gt : lt));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bsort_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsort_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire bsort_pkg::cell_ctl_t  ctl_i,
  input  wire                        odd_i,
  input  wire [bsort_pkg::WIDTH-1:0] left_val_i,
  input  wire                        left_vld_i,
  input  wire [bsort_pkg::WIDTH-1:0] right_val_i,
  input  wire                        right_vld_i,
  output logic [bsort_pkg::WIDTH-1:0] val_o,
  output logic                       vld_o
);

  logic [bsort_pkg::WIDTH-1:0] val_q, val_d;
  logic                        vld_q, vld_d;
  logic                        lower;
  logic                        take_right;
  logic                        take_left;

  assign lower      = (odd_i == ctl_i.parity);
  assign take_right = bsort_pkg::goes_before(right_val_i, right_vld_i, val_q, vld_q,
                                             ctl_i.desc, ctl_i.sgn);
  assign take_left  = bsort_pkg::goes_before(val_q, vld_q, left_val_i, left_vld_i,
                                             ctl_i.desc, ctl_i.sgn);

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    case (ctl_i.op)
      bsort_pkg::OP_LOAD: begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end
      bsort_pkg::OP_EMIT: begin
        val_d = right_val_i;
        vld_d = right_vld_i;
      end
      bsort_pkg::OP_SORT: begin
        if (lower && take_right) begin
          val_d = right_val_i;
          vld_d = right_vld_i;
        end else if (!lower && take_left) begin
          val_d = left_val_i;
          vld_d = left_vld_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

`default_nettype wire

// ----- rtl/block_sorter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Block sorter. Items are loaded with start_i while busy_o is low, one per
// cycle; last_i closes the block. Up to DEPTH values are kept in a row of
// cells; further items are dropped and overflow_o is set on every result of
// that block. The item marked last is still processed (stored or dropped).
// After the closing item the cells run DEPTH rounds of odd-even exchange
// between neighbors (busy_o high), then the block leaves one result per
// cycle from the head cell, res_valid_o high for exactly one cycle each,
// last_res_o on the final one. The first result follows the last exchange
// round; busy_o stays high until the last result of the block has left.
// Order is set by the descending and signed_compare registers, on the cfg
// channel (always ready); the user must write them only while no block is
// being sorted or emitted, not enforced by the block. Results cannot be
// stalled. Reset empties the cells, clears the fill count and both registers.

module block_sorter_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  output logic                           busy_o,
  input  wire [31:0]                     value_i,
  input  wire                            last_i,
  output logic                           res_valid_o,
  output logic [bsort_pkg::DATA_W-1:0]   sorted_value_o,
  output logic                           last_res_o,
  output logic                           overflow_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [bsort_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [bsort_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

  state_e                       state_q;
  logic [bsort_pkg::CNT_W-1:0]  count_q;
  logic [bsort_pkg::RND_W-1:0]  rnd_q;
  logic                         drop_q;
  logic                         desc_q;
  logic                         sgn_q;

  logic                         accept;
  logic                         full;
  bsort_pkg::cell_ctl_t         ctl;

  logic [bsort_pkg::WIDTH-1:0]  cval [bsort_pkg::DEPTH];
  logic                         cvld [bsort_pkg::DEPTH];
  logic [bsort_pkg::WIDTH-1:0]  head_val;
  logic                         head_vld;

  assign accept      = start_i && (state_q == ST_LOAD);
  assign full        = (count_q == bsort_pkg::CNT_W'(bsort_pkg::DEPTH));
  assign busy_o      = (state_q != ST_LOAD);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ctl.parity = rnd_q[0];
    ctl.desc   = desc_q;
    ctl.sgn    = sgn_q;
    case (state_q)
      ST_LOAD: ctl.op = (accept && !full) ? bsort_pkg::OP_LOAD : bsort_pkg::OP_HOLD;
      ST_SORT: ctl.op = bsort_pkg::OP_SORT;
      ST_EMIT: ctl.op = bsort_pkg::OP_EMIT;
      default: ctl.op = bsort_pkg::OP_HOLD;
    endcase
  end

  // head cell sees the new item while loading and itself while sorting
  assign head_val = (state_q == ST_LOAD) ? bsort_pkg::WIDTH'(value_i) : cval[0];
  assign head_vld = (state_q == ST_LOAD) ? 1'b1 : cvld[0];

  for (genvar i = 0; i < bsort_pkg::DEPTH; i++) begin : g_cell
    logic [bsort_pkg::WIDTH-1:0] lv, rv;
    logic                        lvl, rvl;
    if (i == 0) begin : g_first
      assign lv  = head_val;
      assign lvl = head_vld;
    end else begin : g_mid
      assign lv  = cval[i-1];
      assign lvl = cvld[i-1];
    end
    if (i == bsort_pkg::DEPTH - 1) begin : g_end
      assign rv  = cval[i];
      assign rvl = 1'b0;
    end else begin : g_nxt
      assign rv  = cval[i+1];
      assign rvl = cvld[i+1];
    end
    bsort_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .odd_i       (1'(i % 2)),
      .left_val_i  (lv),
      .left_vld_i  (lvl),
      .right_val_i (rv),
      .right_vld_i (rvl),
      .val_o       (cval[i]),
      .vld_o       (cvld[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      rnd_q   <= '0;
      drop_q  <= 1'b0;
      desc_q  <= 1'b0;
      sgn_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bsort_pkg::REG_DESCENDING:     desc_q <= cfg_data_i[0];
          bsort_pkg::REG_SIGNED_COMPARE: sgn_q  <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (full) begin
              drop_q <= 1'b1;
            end else begin
              count_q <= count_q + 1'b1;
            end
            if (last_i) begin
              rnd_q   <= '0;
              state_q <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == bsort_pkg::RND_W'(bsort_pkg::DEPTH - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          count_q <= count_q - 1'b1;
          if (count_q == bsort_pkg::CNT_W'(1)) begin
            drop_q  <= 1'b0;
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign res_valid_o    = (state_q == ST_EMIT);
  assign sorted_value_o = bsort_pkg::DATA_W'(cval[0]);
  assign last_res_o     = (count_q == bsort_pkg::CNT_W'(1));
  assign overflow_o     = drop_q;

endmodule

`default_nettype wire

// ----- bench/block_sorter_core_tb.sv -----
`timescale 1ns / 1ps

module block_sorter_core_tb;

  localparam int DEPTH_N        = bsort_pkg::DEPTH;
  localparam int ITEM_BUDGET    = 400;
  localparam int WATCHDOG_LIMIT = 16 * DEPTH_N;

  localparam logic [bsort_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = bsort_pkg::CFG_IDX_W'(2);
  localparam logic [bsort_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_CFG,
    ROW_DRAIN
  } row_kind_e;

  // load rows: data is the value; typed rows are one-value blocks with exp as the result
  typedef struct packed {
    row_kind_e                       kind;
    logic [bsort_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                     data;
    logic                            last;
    logic                            typed;
    logic [31:0]                     exp;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        ovf;
  } sorted_word_t;

  localparam int N_DIR = 31;
  localparam stim_row_t DIR_TAB [N_DIR] = '{
    '{ROW_LOAD,  '0,                 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_LOAD,  '0,                 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_LOAD,  '0,                 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{ROW_DRAIN, '0,                 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_CFG,   bsort_pkg::REG_SIGNED_COMPARE, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{ROW_DRAIN, '0,                 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_CFG,   bsort_pkg::REG_DESCENDING,     32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_0005, 1'b1, 1'b0, 32'h0},
    '{ROW_DRAIN, '0,                 32'h0,         1'b0, 1'b0, 32'h0},
    '{ROW_CFG,   REG_UNUSED_LO,      32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,   REG_UNUSED_HI,      32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_0003, 1'b1, 1'b1, 32'h0000_0003},
    '{ROW_LOAD,  '0,                 32'h0000_1234, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'hABCD_0000, 1'b0, 1'b0, 32'h0},
    // order registers change while this block is still open
    '{ROW_CFG,   bsort_pkg::REG_DESCENDING,     32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG,   bsort_pkg::REG_SIGNED_COMPARE, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_LOAD,  '0,                 32'h0000_00FF, 1'b1, 1'b0, 32'h0},
    '{ROW_DRAIN, '0,                 32'h0,         1'b0, 1'b0, 32'h0}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic [31:0]                     value_i;
  logic                            last_i;
  logic                            res_valid_o;
  logic [bsort_pkg::DATA_W-1:0]    sorted_value_o;
  logic                            last_res_o;
  logic                            overflow_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [bsort_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [bsort_pkg::CFG_DAT_W-1:0] cfg_data_i;

  // travels with each item: a typed expectation replaces the predicted one
  logic        fixed_exp_vld;
  logic [31:0] fixed_exp_val;

  logic [31:0]  open_blk [$];
  logic         blk_dropped;
  logic         desc_ord;
  logic         sgn_cmp;
  sorted_word_t sorted_exp_q [$];
  logic [31:0]  recent_val;

  int n_errs;
  int n_items;
  int n_blocks;
  int n_results;
  int n_ovf;
  int n_cfg;
  int idle_cycles;

  block_sorter_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .res_valid_o    (res_valid_o),
    .sorted_value_o (sorted_value_o),
    .last_res_o     (last_res_o),
    .overflow_o     (overflow_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    n_errs++;
  endtask

  function automatic logic goes_first(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a;
    kb = b;
    if (sgn_cmp) begin
      ka[31] = ~ka[31];
      kb[31] = ~kb[31];
    end
    return desc_ord ? (ka > kb) : (ka < kb);
  endfunction

  task automatic take_item();
    sorted_word_t w;
    logic [31:0]  v;
    int           pos;
    n_items++;
    if (open_blk.size() < DEPTH_N) begin
      open_blk.push_back(value_i);
    end else begin
      blk_dropped = 1'b1;
    end
    if (last_i) begin
      for (int i = 1; i < open_blk.size(); i++) begin
        v = open_blk[i];
        pos = i;
        while (pos > 0 && goes_first(v, open_blk[pos-1])) begin
          open_blk[pos] = open_blk[pos-1];
          pos--;
        end
        open_blk[pos] = v;
      end
      if (fixed_exp_vld) begin
        w = '{fixed_exp_val, 1'b1, 1'b0};
        sorted_exp_q.push_back(w);
      end else begin
        foreach (open_blk[k]) begin
          w = '{open_blk[k], (k == open_blk.size() - 1), blk_dropped};
          sorted_exp_q.push_back(w);
        end
      end
      open_blk.delete();
      blk_dropped = 1'b0;
      n_blocks++;
    end
  endtask

  task automatic check_result();
    sorted_word_t want;
    n_results++;
    if (overflow_o) n_ovf++;
    if (sorted_exp_q.size() == 0) begin
      report_mismatch("unexpected result", sorted_value_o, '0);
    end else begin
      want = sorted_exp_q.pop_front();
      if (sorted_value_o !== want.value) report_mismatch("sorted_value", sorted_value_o, want.value);
      if (last_res_o !== want.last) report_mismatch("last_res", 32'(last_res_o), 32'(want.last));
      if (overflow_o !== want.ovf) report_mismatch("overflow", 32'(overflow_o), 32'(want.ovf));
    end
  endtask

  always @(posedge clk_i) begin
    if (res_valid_o || (cfg_valid_i && cfg_ready_o) || (start_i && !busy_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (rst_ni) begin
      if (res_valid_o) check_result();
      if (cfg_valid_i && cfg_ready_o) begin
        n_cfg++;
        if (cfg_index_i == bsort_pkg::REG_DESCENDING) desc_ord = cfg_data_i[0];
        else if (cfg_index_i == bsort_pkg::REG_SIGNED_COMPARE) sgn_cmp = cfg_data_i[0];
      end
      if (start_i && !busy_o) take_item();
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("block_sorter_core_tb: FAIL");
    $finish;
  end

  task automatic load_item(input logic [31:0] v, input logic closes, input logic typed,
                           input logic [31:0] exp);
    start_i       <= 1'b1;
    value_i       <= v;
    last_i        <= closes;
    fixed_exp_vld <= typed;
    fixed_exp_val <= exp;
    cfg_valid_i   <= 1'b0;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_reg(input logic [bsort_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsort_pkg::CFG_DAT_W-1:0] data);
    start_i     <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic hold_off(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // one edge first so the closing item is seen by the checker and the core
  task automatic wait_idle();
    start_i     <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o || sorted_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0: v = 32'h7FFF_FFFE + $urandom_range(0, 3);
      1: v = $urandom_range(0, 7);
      2: v = 32'hFFFF_FFFF - $urandom_range(0, 7);
      3: v = recent_val;
      default: v = $urandom();
    endcase
    recent_val = v;
    return v;
  endfunction

  initial begin
    logic [1:0] setting;
    int         blk_len;
    int         phase_items;
    int         blk_no;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    value_i       = '0;
    last_i        = 1'b0;
    fixed_exp_vld = 1'b0;
    fixed_exp_val = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    blk_dropped   = 1'b0;
    desc_ord      = 1'b0;
    sgn_cmp       = 1'b0;
    recent_val    = '0;
    n_errs        = 0;
    n_items       = 0;
    n_blocks      = 0;
    n_results     = 0;
    n_ovf         = 0;
    n_cfg         = 0;
    idle_cycles   = 0;
    blk_no        = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIR; r++) begin
      case (DIR_TAB[r].kind)
        ROW_LOAD: begin
          load_item(DIR_TAB[r].data, DIR_TAB[r].last, DIR_TAB[r].typed, DIR_TAB[r].exp);
        end
        ROW_CFG: begin
          write_reg(DIR_TAB[r].idx, DIR_TAB[r].data);
        end
        default: begin
          wait_idle();
        end
      endcase
    end

    // one phase per order setting; the last phase runs without gaps
    for (int p = 0; p < 4; p++) begin
      setting = 2'(p);
      wait_idle();
      write_reg(bsort_pkg::REG_DESCENDING,
                {31'($urandom_range(0, 32'h7FFF_FFFF)), setting[0]});
      write_reg(bsort_pkg::REG_SIGNED_COMPARE,
                {31'($urandom_range(0, 32'h7FFF_FFFF)), setting[1]});
      phase_items = 0;
      while (phase_items < ITEM_BUDGET / 4) begin
        if (blk_no % 12 == 1) blk_len = $urandom_range(DEPTH_N + 1, DEPTH_N + 4);
        else if (blk_no % 12 == 7) blk_len = $urandom_range(DEPTH_N - 1, DEPTH_N);
        else if ($urandom_range(0, 4) == 0) blk_len = $urandom_range(9, 40);
        else blk_len = $urandom_range(1, 8);
        for (int k = 0; k < blk_len; k++) begin
          load_item(rand_value(), (k == blk_len - 1), 1'b0, '0);
          if (p < 3 && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
        end
        phase_items += blk_len;
        blk_no++;
      end
    end

    wait_idle();
    repeat (DEPTH_N + 16) @(posedge clk_i);
    if (sorted_exp_q.size() != 0) begin
      report_mismatch("results never produced", 32'(sorted_exp_q.size()), '0);
    end
    $display("block_sorter_core_tb: %0d items in %0d blocks, %0d results, %0d register writes",
             n_items, n_blocks, n_results, n_cfg);
    $display("block_sorter_core_tb: all four order settings, %0d results flagged overflow",
             n_ovf);
    if (n_errs == 0) begin
      $display("block_sorter_core_tb: PASS");
    end else begin
      $display("block_sorter_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bsort_pkg.sv
rtl/bsort_cell.sv
rtl/block_sorter_core.sv
bench/block_sorter_core_tb.sv
